FILE: sv/nsc_pkg.sv
package nsc_pkg;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_SHORT    = 3'd1;
  localparam logic [2:0] STATUS_NO_STAR  = 3'd2;
  localparam logic [2:0] STATUS_BAD_CHAR = 3'd3;
  localparam logic [2:0] STATUS_MISMATCH = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_RMC  = 2'd1;
  localparam logic [1:0] KIND_GSA  = 2'd2;
  localparam logic [1:0] KIND_GGA  = 2'd3;

  localparam logic [7:0] CHAR_STAR = 8'h2a;
  localparam logic [7:0] HEX_DIGIT_BASE  = 8'h30;
  localparam logic [7:0] HEX_LETTER_BASE = 8'h37;

  localparam int HDR_COUNT = 6;
  localparam int HDR_LEN   = 6;
  localparam int WIN_DEPTH = 5;

  // header patterns, first character in the top byte
  localparam logic [8*HDR_LEN-1:0] HDR_PAT [HDR_COUNT] = '{
    "$GPRMC", "$GNRMC", "$GPGSA", "$GNGSA", "$GPGGA", "$GNGGA"
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] check_status;
    logic [1:0] sentence_kind;
    logic [7:0] computed_checksum;
  } result_t;

  function automatic logic [7:0] hdr_char(input int k, input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = HDR_PAT[k][47:40];
      3'd1:    c = HDR_PAT[k][39:32];
      3'd2:    c = HDR_PAT[k][31:24];
      3'd3:    c = HDR_PAT[k][23:16];
      3'd4:    c = HDR_PAT[k][15:8];
      3'd5:    c = HDR_PAT[k][7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    return {4'h0, n} + ((n < 4'ha) ? HEX_DIGIT_BASE : HEX_LETTER_BASE);
  endfunction

endpackage

FILE: sv/nmea_sentence_checksum_check_core.sv
// NMEA 0183 sentence checksum checker.
// Input channel s_axis: one sentence byte per item in tdata[7:0], tlast on the
// final byte. Output channel m_axis: one result item per sentence, given when
// the final byte has been processed; no item is produced for other bytes.
// Result: tdata[2:0] status (ok, short, no star, bad character, mismatch),
// tdata[10:3] computed XOR, tuser[1:0] sentence kind (RMC, GSA, GGA or none).
// A final byte passes through the input register, then the result register,
// before its result shows on m_axis. Throughput: one byte per cycle, unless a
// final byte waits on a stalled m_axis; the running XOR, five-byte tail window
// and header match flags all update as each byte leaves the input register.
// Reset clears both valid flags and returns the sentence state to the start of
// a sentence. While m_axis stalls the result holds; bytes that are not final
// keep flowing, and a further final byte waits in the input register until
// the held result is taken, which then stalls s_axis.
module nmea_sentence_checksum_check_core
  import nsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] check_status, [10:3] computed_checksum
  output logic [1:0]  m_axis_tuser    // [1:0] sentence_kind
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  result_t result;
  result_t out_result;

  assign in_item.data_byte = s_axis_tdata;
  assign in_item.last_byte = s_axis_tlast;

  nsc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  nsc_check u_check (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .result  (result)
  );

  nsc_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_last  (held_item.last_byte),
    .result     (result),
    .advance    (advance),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (out_result)
  );

  assign m_axis_tdata = {5'b00000, out_result.computed_checksum, out_result.check_status};
  assign m_axis_tuser = out_result.sentence_kind;

endmodule

FILE: sv/nsc_in_stage.sv
module nsc_in_stage
  import nsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  held_valid,
  output item_t held_item
);

  logic  vld;
  item_t item;

  assign in_ready   = !vld || advance;
  assign held_valid = vld;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

FILE: sv/nsc_check.sv
module nsc_check
  import nsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  output result_t result
);

  logic [7:0]          tail_window [WIN_DEPTH];
  logic [7:0]          running_xor;
  logic [2:0]          byte_position;
  logic                bad_char_seen;
  logic [HDR_COUNT-1:0] header_match_flags;

  logic [7:0]          win_next [WIN_DEPTH];
  logic [7:0]          xor_next;
  logic [2:0]          pos_next;
  logic                bad_next;
  logic [HDR_COUNT-1:0] flags_next;
  logic [7:0]          leaving;
  logic                in_payload;

  assign leaving    = tail_window[0];
  assign in_payload = (byte_position >= 3'd6);

  always_comb begin
    for (int k = 0; k < HDR_COUNT; k++) begin
      flags_next[k] = header_match_flags[k] &&
                      (in_payload || byte_position == 3'd7 ||
                       hdr_char(k, byte_position) == item.data_byte);
    end
    xor_next = in_payload ? (running_xor ^ leaving) : running_xor;
    bad_next = bad_char_seen || (in_payload && (leaving[7] || leaving == 8'h00));
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      win_next[i] = tail_window[i+1];
    end
    win_next[WIN_DEPTH-1] = item.data_byte;
    pos_next = (byte_position == 3'd7) ? byte_position : byte_position + 3'd1;
  end

  // precedence: short, no star, bad character, mismatch
  always_comb begin
    result.computed_checksum = xor_next;
    result.sentence_kind     = KIND_NONE;
    if (byte_position < 3'd5) begin
      result.check_status = STATUS_SHORT;
    end else if (win_next[0] != CHAR_STAR) begin
      result.check_status = STATUS_NO_STAR;
    end else if (bad_next) begin
      result.check_status = STATUS_BAD_CHAR;
    end else if (win_next[1] != nibble_char(xor_next[7:4]) ||
                 win_next[2] != nibble_char(xor_next[3:0])) begin
      result.check_status = STATUS_MISMATCH;
    end else begin
      result.check_status = STATUS_OK;
      if (|flags_next[1:0]) begin
        result.sentence_kind = KIND_RMC;
      end else if (|flags_next[3:2]) begin
        result.sentence_kind = KIND_GSA;
      end else if (|flags_next[5:4]) begin
        result.sentence_kind = KIND_GGA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && item.last_byte)) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        tail_window[i] <= 8'h00;
      end
      running_xor        <= 8'h00;
      byte_position      <= 3'd0;
      bad_char_seen      <= 1'b0;
      header_match_flags <= '1;
    end else if (advance) begin
      tail_window        <= win_next;
      running_xor        <= xor_next;
      byte_position      <= pos_next;
      bad_char_seen      <= bad_next;
      header_match_flags <= flags_next;
    end
  end

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && item.last_byte |=> byte_position == 3'd0 && header_match_flags == '1)
    else $error("sentence state not cleared after final item");

  a_position_counts: assert property (@(posedge clk) disable iff (rst)
    advance && !item.last_byte && byte_position != 3'd7
      |=> byte_position == $past(byte_position) + 3'd1)
    else $error("byte position did not advance");

  a_kind_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    advance && result.sentence_kind != KIND_NONE |-> result.check_status == STATUS_OK)
    else $error("sentence kind given on a failed check");

  a_flags_only_fall: assert property (@(posedge clk) disable iff (rst)
    advance && !item.last_byte
      |=> (header_match_flags & ~$past(header_match_flags)) == '0)
    else $error("header match flag set again mid sentence");

endmodule

FILE: sv/nsc_out_stage.sv
module nsc_out_stage
  import nsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    held_valid,
  input  logic    held_last,
  input  result_t result,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    vld;
  result_t res;
  logic    load;

  // a non-final item needs no output slot
  assign advance    = held_valid && (!held_last || !vld || out_ready);
  assign load       = advance && held_last;
  assign out_valid  = vld;
  assign out_result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
    end else if (out_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= result;
    end
  end

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    vld && !out_ready |=> vld && res == $past(res))
    else $error("result item lost while stalled");

endmodule
